@@ src/pws_pkg.sv @@
`timescale 1ns / 1ps

package pws_pkg;

  localparam int DATA_W    = 16;
  localparam int MAG_W     = DATA_W + 1;
  localparam int WIDE_W    = DATA_W + MAG_W + 1;
  localparam int NUM_COEFS = 4;
  localparam int IDX_W     = $clog2(NUM_COEFS);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic [MAG_W-1:0]         mag;
    logic signed [DATA_W-1:0] acc;
  } item_t;

  function automatic data_t sat_data(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = WIDE_W'(DATA_MAX);
    lo = WIDE_W'(DATA_MIN);
    if (v > hi) begin
      return DATA_MAX;
    end else if (v < lo) begin
      return DATA_MIN;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

@@ src/pws_horner_step.sv @@
`timescale 1ns / 1ps

module pws_horner_step #(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pws_pkg::item_t        in_item_i,
  input  pws_pkg::data_t        coef_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pws_pkg::item_t        out_item_o
);
  import pws_pkg::*;

  logic  mul_valid_q;
  item_t mul_item_q;
  wide_t prod_q;
  wide_t prod_d;
  logic  add_valid_q;
  item_t add_item_q;
  item_t add_item_d;
  logic  mul_ready;
  logic  add_ready;
  wide_t shifted;
  data_t scaled;
  wide_t sum;

  assign add_ready  = !add_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || add_ready;
  assign in_ready_o = mul_ready;

  assign prod_d = WIDE_W'(in_item_i.acc * $signed({1'b0, in_item_i.mag}));

  always_comb begin
    shifted        = prod_q >>> FRAC_BITS;
    scaled         = sat_data(shifted);
    sum            = WIDE_W'(scaled) + WIDE_W'(coef_i);
    add_item_d     = mul_item_q;
    add_item_d.acc = sat_data(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      add_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= in_valid_i;
      end
      if (add_ready) begin
        add_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      mul_item_q <= in_item_i;
      prod_q     <= prod_d;
    end
    if (add_ready && mul_valid_q) begin
      add_item_q <= add_item_d;
    end
  end

  assign out_valid_o = add_valid_q;
  assign out_item_o  = add_item_q;

endmodule

@@ src/polynomial_weight_shrinker.sv @@
`timescale 1ns / 1ps
// Channel    Direction  Payload
// s_axis     in         tdata[15:0] weight_in
// m_axis     out        tdata[15:0] weight_out, tuser[0] clipped
// cfg        in         cfg_idx_i selects coef_deg0..coef_deg3, cfg_wdata_i value
//
// An accepted item passes the input register, each step's multiply and add registers, then the result register.
// One item can enter in every cycle unless a stall on m_axis has backed up to the input register.
// Each Horner step is a multiply stage followed by a shift, saturate and add stage.
// Reset clears all valid bits and sets every coefficient to zero.
// A stall on m_axis fills empty stages first; nothing is lost or repeated.

module polynomial_weight_shrinker #(
  parameter int NUM_TERMS = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,  // [15:0] weight_in
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [15:0] weight_out
  output logic [0:0]                 m_axis_tuser,  // [0] clipped
  input  logic                       cfg_we_i,
  input  logic [pws_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [15:0]                cfg_wdata_i
);
  import pws_pkg::*;

  localparam int NUM_STEPS = NUM_TERMS - 1;

  data_t coef_q [NUM_COEFS];

  logic  link_valid [NUM_TERMS];
  logic  link_ready [NUM_TERMS];
  item_t link_item  [NUM_TERMS];

  logic  in_valid_q;
  item_t in_item_q;
  item_t in_item_d;
  logic  in_ready;

  logic  out_valid_q;
  data_t out_weight_q;
  data_t out_weight_d;
  logic  out_clip_q;
  logic  out_clip_d;
  logic  out_ready;

  logic signed [DATA_W+1:0] acc_ext;
  logic signed [DATA_W+1:0] mag_ext;
  logic signed [DATA_W:0]   res_wide;
  item_t                    fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_item_d.weight = s_axis_tdata;
    in_item_d.mag    = s_axis_tdata[DATA_W-1]
                     ? MAG_W'(-$signed({s_axis_tdata[DATA_W-1], s_axis_tdata}))
                     : {1'b0, s_axis_tdata};
    in_item_d.acc    = coef_q[NUM_TERMS-1];
  end

  assign in_ready      = !in_valid_q || link_ready[0];
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
  end

  assign link_valid[0] = in_valid_q;
  assign link_item[0]  = in_item_q;

  for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
    pws_horner_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[j]),
      .in_ready_o  (link_ready[j]),
      .in_item_i   (link_item[j]),
      .coef_i      (coef_q[NUM_TERMS-2-j]),
      .out_valid_o (link_valid[j+1]),
      .out_ready_i (link_ready[j+1]),
      .out_item_o  (link_item[j+1])
    );
  end

  assign out_ready                = !out_valid_q || m_axis_tready;
  assign link_ready[NUM_TERMS-1]  = out_ready;

  always_comb begin
    fin      = link_item[NUM_TERMS-1];
    acc_ext  = (DATA_W+2)'(fin.acc);
    mag_ext  = $signed({1'b0, fin.mag});
    res_wide = fin.weight[DATA_W-1]
             ? (DATA_W+1)'(fin.weight) + (DATA_W+1)'(fin.acc)
             : (DATA_W+1)'(fin.weight) - (DATA_W+1)'(fin.acc);
    if (acc_ext > mag_ext) begin
      out_weight_d = '0;
      out_clip_d   = 1'b0;
    end else if (res_wide[DATA_W] != res_wide[DATA_W-1]) begin
      out_weight_d = res_wide[DATA_W] ? DATA_MIN : DATA_MAX;
      out_clip_d   = 1'b1;
    end else begin
      out_weight_d = res_wide[DATA_W-1:0];
      out_clip_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= link_valid[NUM_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && link_valid[NUM_TERMS-1]) begin
      out_weight_q <= out_weight_d;
      out_clip_q   <= out_clip_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_weight_q;
  assign m_axis_tuser[0] = out_clip_q;

endmodule
